// File: rtl/bale_pkg.sv
// Package for the bounded array list engine.
// Holds command and status codes and the request and result struct types.
// No dependencies.
`default_nettype none

package bale_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W   = 3;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT_HEAD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT_SORTED = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ          = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE        = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR         = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic                     is_full;
        logic [STAT_W-1:0]        status;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/bale_ram.sv
// Entry store of the list engine: one write port, one registered read port.
// Depends on bale_pkg for the data width.
`default_nettype none

module bale_ram
    import bale_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bounded_array_list_engine_unit.sv
// Bounded array list engine: a list of up to CAPACITY signed 32-bit entries
// kept in one single-port-read, single-port-write memory. A request is taken
// when start is high and busy is low; its result shows on result for one cycle
// with done high and must be taken then. Append, clear, unused codes and
// refused requests give their result in the cycle after the request; a read
// first passes through the read wait state. Insert at head shifts every entry
// up and remove shifts the entries above the index down, one entry moved per
// cycle through the memory. Sorted insert runs the insert as a first
// compare-and-swap pass and then repeats bubble passes until a pass makes no
// swap: at most two passes on a list that was already sorted, up to count + 1
// passes on an unsorted one. Every pass is paced by the memory's one read and
// one write per cycle. The memory needs no clearing after reset.
// Depends on bale_pkg and bale_ram.
`default_nettype none

module bounded_array_list_engine_unit
    import bale_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  req_t    request,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Controller states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RDWAIT = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;

    // Walk kinds
    localparam logic [1:0] M_SHIFT_UP   = 2'd0;
    localparam logic [1:0] M_SORT_FIRST = 2'd1;
    localparam logic [1:0] M_BUBBLE     = 2'd2;
    localparam logic [1:0] M_SHIFT_DOWN = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     rd_end_reg, rd_end_next;
    logic              rd_on_reg, rd_on_next;
    logic              pend_reg, pend_next;
    logic [CW-1:0]     pend_addr_reg, pend_addr_next;
    logic [CW-1:0]     fin_addr_reg, fin_addr_next;
    logic [DATA_W-1:0] carry_reg, carry_next;
    logic              swap_reg, swap_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              list_full;
    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     cnt_x;
    logic              idx_ok;
    logic              data_less;
    logic [DATA_W-1:0] lo_val;
    logic [DATA_W-1:0] hi_val;
    logic [CW-1:0]     pend_prev;

    bale_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic result_t mk_result(
        input logic [DATA_W-1:0] rd,
        input logic [CW-1:0]     cnt,
        input logic [STAT_W-1:0] st
    );
        result_t r;
        r.read_value  = rd;
        r.entry_count = COUNT_W'(cnt);
        r.is_empty    = (cnt == '0);
        r.is_full     = (cnt == CAP_C);
        r.status      = st;
        return r;
    endfunction

    // Request decode helpers
    assign list_full = (count_reg == CAP_C);
    assign idx_x     = XW'(request.index);
    assign cnt_x     = XW'(count_reg);
    assign idx_ok    = (idx_x < cnt_x);

    // Compare-and-swap of the arriving entry against the carried one
    assign data_less = ($signed(ram_rdata) < $signed(carry_reg));
    assign lo_val    = data_less ? ram_rdata : carry_reg;
    assign hi_val    = data_less ? carry_reg : ram_rdata;
    assign pend_prev = pend_addr_reg - CW'(1);

    // Controller and memory port steering
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_end_next    = rd_end_reg;
        rd_on_next     = rd_on_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        fin_addr_next  = fin_addr_reg;
        carry_next     = carry_reg;
        swap_next      = swap_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pend_next = 1'b0;
                    swap_next = 1'b0;
                    case (request.cmd)
                        CMD_APPEND:
                        begin
                            if (list_full)
                            begin
                                done_next   = 1'b1;
                                result_next = mk_result('0, count_reg, ST_FULL);
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[AW-1:0];
                                ram_wdata   = request.value;
                                count_next  = count_reg + CW'(1);
                                done_next   = 1'b1;
                                result_next = mk_result('0, count_next, ST_OK);
                            end
                        end
                        CMD_INSERT_HEAD, CMD_INSERT_SORTED:
                        begin
                            if (list_full)
                            begin
                                done_next   = 1'b1;
                                result_next = mk_result('0, count_reg, ST_FULL);
                            end
                            else
                            begin
                                mode_next     = (request.cmd == CMD_INSERT_SORTED) ?
                                                M_SORT_FIRST : M_SHIFT_UP;
                                carry_next    = request.value;
                                rd_ptr_next   = '0;
                                rd_end_next   = count_reg - CW'(1);
                                rd_on_next    = (count_reg != '0);
                                fin_addr_next = count_reg;
                                count_next    = count_reg + CW'(1);
                                state_next    = S_WALK;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!idx_ok)
                            begin
                                done_next   = 1'b1;
                                result_next = mk_result('0, count_reg, ST_RANGE);
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = idx_x[AW-1:0];
                                state_next = S_RDWAIT;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!idx_ok)
                            begin
                                done_next   = 1'b1;
                                result_next = mk_result('0, count_reg, ST_RANGE);
                            end
                            else
                            begin
                                mode_next   = M_SHIFT_DOWN;
                                rd_ptr_next = CW'(idx_x) + CW'(1);
                                rd_end_next = count_reg - CW'(1);
                                rd_on_next  = ((idx_x + XW'(1)) < cnt_x);
                                count_next  = count_reg - CW'(1);
                                state_next  = S_WALK;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next  = '0;
                            done_next   = 1'b1;
                            result_next = mk_result('0, '0, ST_OK);
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = mk_result('0, count_reg, ST_OK);
                        end
                    endcase
                end
            end

            S_RDWAIT:
            begin
                done_next   = 1'b1;
                result_next = mk_result(ram_rdata, count_reg, ST_OK);
                state_next  = S_IDLE;
            end

            S_WALK:
            begin
                // Read side runs ahead of the write side by one entry
                if (rd_on_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_ptr_reg[AW-1:0];
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                    if (rd_ptr_reg == rd_end_reg)
                    begin
                        rd_on_next = 1'b0;
                    end
                end
                pend_next      = rd_on_reg;
                pend_addr_next = rd_ptr_reg;

                if (pend_reg)
                begin
                    // Entry read last cycle has arrived
                    case (mode_reg)
                        M_SHIFT_UP:
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = pend_addr_reg[AW-1:0];
                            ram_wdata  = carry_reg;
                            carry_next = ram_rdata;
                        end
                        M_SORT_FIRST:
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = pend_addr_reg[AW-1:0];
                            ram_wdata  = lo_val;
                            carry_next = hi_val;
                            swap_next  = swap_reg | data_less;
                        end
                        M_BUBBLE:
                        begin
                            if (pend_addr_reg == '0)
                            begin
                                carry_next = ram_rdata;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = pend_prev[AW-1:0];
                                ram_wdata  = lo_val;
                                carry_next = hi_val;
                                swap_next  = swap_reg | data_less;
                            end
                        end
                        default:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pend_prev[AW-1:0];
                            ram_wdata = ram_rdata;
                        end
                    endcase
                end
                else if (!rd_on_reg)
                begin
                    // End of pass: flush the carried entry, then repeat or finish
                    if (mode_reg != M_SHIFT_DOWN)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = fin_addr_reg[AW-1:0];
                        ram_wdata = carry_reg;
                    end
                    if ((mode_reg != M_SHIFT_UP) && (mode_reg != M_SHIFT_DOWN) &&
                        swap_reg)
                    begin
                        mode_next     = M_BUBBLE;
                        rd_ptr_next   = '0;
                        rd_end_next   = count_reg - CW'(1);
                        rd_on_next    = 1'b1;
                        fin_addr_next = count_reg - CW'(1);
                        swap_next     = 1'b0;
                    end
                    else
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        result_next = mk_result('0, count_reg, ST_OK);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rd_on_reg <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_on_reg <= rd_on_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Walk datapath and result registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        rd_ptr_reg    <= rd_ptr_next;
        rd_end_reg    <= rd_end_next;
        pend_addr_reg <= pend_addr_next;
        fin_addr_reg  <= fin_addr_next;
        carry_reg     <= carry_next;
        swap_reg      <= swap_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/bale_checker.sv
// Port-level checks for the bounded array list engine, bound to its top level.
// Depends on bale_pkg for the result type and status codes.
`default_nettype none

module bale_checker
    import bale_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    done,
    input wire result_t result
);

    // An accepted request either completes next cycle or holds the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither busy nor done");

    // Leaving busy always delivers a result
    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A nonzero read value only comes with a successful request
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.read_value != '0)) |-> (result.status == ST_OK))
        else $error("read value on a failed request");

    // The list cannot be empty and full at once
    a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.is_empty && result.is_full))
        else $error("empty and full together");

    // A refused insert reports a full list
    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> result.is_full)
        else $error("insert refused on a list that is not full");

endmodule

bind bounded_array_list_engine_unit bale_checker u_bale_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for bounded_array_list_engine_unit.
// Keeps a shadow copy of the list to predict every result; needs bale_pkg
// and the engine RTL only.
`timescale 1ns / 1ps

import bale_pkg::*;

localparam int LIST_CAPACITY = 64;

// Codes the engine must ignore
localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

// Shadow of the list contents plus the queue of predicted results
class list_tracker;
    logic signed [DATA_W-1:0] slots [LIST_CAPACITY];
    int unsigned fill;
    result_t     expected_results [$];
    int unsigned errors;
    int unsigned accepted;
    int unsigned checked;
    int unsigned full_results;
    int unsigned refused;
    int unsigned out_of_range;
    int unsigned sorted_inserts;

    function new();
        fill           = 0;
        errors         = 0;
        accepted       = 0;
        checked        = 0;
        full_results   = 0;
        refused        = 0;
        out_of_range   = 0;
        sorted_inserts = 0;
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    // Apply one accepted request to the shadow list and queue its result
    function void note_request(req_t req);
        result_t                  res;
        logic signed [DATA_W-1:0] key;
        int                       i;
        int                       j;
        res = '0;
        accepted++;
        case (req.cmd)
            CMD_APPEND:
            begin
                if (fill >= LIST_CAPACITY)
                begin
                    res.status = ST_FULL;
                    refused++;
                end
                else
                begin
                    slots[fill] = req.value;
                    fill++;
                end
            end
            CMD_INSERT_HEAD, CMD_INSERT_SORTED:
            begin
                if (fill >= LIST_CAPACITY)
                begin
                    res.status = ST_FULL;
                    refused++;
                end
                else
                begin
                    for (i = fill; i > 0; i--)
                        slots[i] = slots[i-1];
                    slots[0] = req.value;
                    fill++;
                    // insertion sort, signed ascending
                    if (req.cmd == CMD_INSERT_SORTED)
                    begin
                        sorted_inserts++;
                        for (i = 1; i < fill; i++)
                        begin
                            key = slots[i];
                            j   = i;
                            while (j > 0 && slots[j-1] > key)
                            begin
                                slots[j] = slots[j-1];
                                j--;
                            end
                            slots[j] = key;
                        end
                    end
                end
            end
            CMD_READ:
            begin
                if (req.index >= fill)
                begin
                    res.status = ST_RANGE;
                    out_of_range++;
                end
                else
                    res.read_value = slots[req.index];
            end
            CMD_REMOVE:
            begin
                if (req.index >= fill)
                begin
                    res.status = ST_RANGE;
                    out_of_range++;
                end
                else
                begin
                    for (i = req.index; i + 1 < fill; i++)
                        slots[i] = slots[i+1];
                    fill--;
                end
            end
            CMD_CLEAR:
                fill = 0;
            default:
                ;
        endcase
        res.entry_count = COUNT_W'(fill);
        res.is_empty    = (fill == 0);
        res.is_full     = (fill == LIST_CAPACITY);
        if (res.is_full)
            full_results++;
        expected_results.push_back(res);
    endfunction

    // Compare one result from the engine with the oldest prediction
    task check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            report($sformatf("result %h with no request outstanding", got));
            return;
        end
        want = expected_results.pop_front();
        checked++;
        if (got.read_value !== want.read_value)
            report($sformatf("result %0d read_value %0d, predicted %0d",
                             checked, got.read_value, want.read_value));
        if (got.entry_count !== want.entry_count)
            report($sformatf("result %0d entry_count %0d, predicted %0d",
                             checked, got.entry_count, want.entry_count));
        if (got.is_empty !== want.is_empty)
            report($sformatf("result %0d is_empty %b, predicted %b",
                             checked, got.is_empty, want.is_empty));
        if (got.is_full !== want.is_full)
            report($sformatf("result %0d is_full %b, predicted %b",
                             checked, got.is_full, want.is_full));
        if (got.status !== want.status)
            report($sformatf("result %0d status %0d, predicted %0d",
                             checked, got.status, want.status));
    endtask
endclass

module testbench;

    localparam int          TAIL_CYCLES  = 4700;
    localparam int unsigned CYCLE_LIMIT  = 25_000_000;
    localparam int          RANDOM_ITEMS = 1100;

    logic    clk;
    logic    rst_n;
    logic    start;
    req_t    request;
    logic    busy;
    logic    done;
    result_t result;

    list_tracker tracker;
    bit          steady;
    int unsigned issued;
    int unsigned cycle_count;
    int unsigned base_count;

    bounded_array_list_engine_unit #(
        .CAPACITY (LIST_CAPACITY)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watch both sides of the handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_result(result);
            if (start && !busy)
                tracker.note_request(request);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic req_t make_req(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v,
                                      logic [IDX_W-1:0] idx);
        req_t r;
        r.cmd   = c;
        r.value = v;
        r.index = idx;
        return r;
    endfunction

    // Mix of wide random, clustered small values and extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            1: return int'($urandom_range(0, 16)) - 8;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0;
                    default: return -32'sh1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Mostly a valid position, sometimes anywhere
    function automatic logic [IDX_W-1:0] pick_index();
        if (tracker.fill > 0 && $urandom_range(0, 9) != 0)
            return IDX_W'($urandom_range(0, tracker.fill - 1));
        return IDX_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [CMD_W-1:0] pick_insert(bit sorted_only);
        if (sorted_only)
            return CMD_INSERT_SORTED;
        case ($urandom_range(0, 2))
            0: return CMD_APPEND;
            1: return CMD_INSERT_HEAD;
            default: return CMD_INSERT_SORTED;
        endcase
    endfunction

    // Present one request from the falling edge and hold it until taken
    task automatic issue_request(req_t req);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (req.cmd <= CMD_CLEAR)
            issued++;
        @(negedge clk);
    endtask

    // Build the list toward a target size with reads and removes mixed in
    task automatic grow_episode();
        int unsigned target;
        int          ops;
        int          pick;
        bit          sorted_only;
        target      = ($urandom_range(0, 9) == 0) ? $urandom_range(20, LIST_CAPACITY)
                                                  : $urandom_range(1, 12);
        ops         = $urandom_range(10, 40);
        sorted_only = ($urandom_range(0, 2) == 0);
        repeat (ops)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                issue_request(make_req(CMD_CLEAR, pick_value(),
                                       IDX_W'($urandom_range(0, 63))));
            else if (pick < ((tracker.fill < target) ? 60 : 20))
                issue_request(make_req(pick_insert(sorted_only), pick_value(),
                                       IDX_W'($urandom_range(0, 63))));
            else if (pick < 80)
                issue_request(make_req(CMD_READ, pick_value(), pick_index()));
            else
                issue_request(make_req(CMD_REMOVE, pick_value(), pick_index()));
        end
    endtask

    // Run the list to capacity, try refused inserts, drain a little, then refill it
    task automatic fill_episode();
        while (tracker.fill < LIST_CAPACITY)
            issue_request(make_req(pick_insert(1'b0), pick_value(),
                                   IDX_W'($urandom_range(0, 63))));
        repeat ($urandom_range(2, 6))
            issue_request(make_req(pick_insert(1'b0), pick_value(),
                                   IDX_W'($urandom_range(0, 63))));
        repeat ($urandom_range(3, 10))
            issue_request(make_req(CMD_READ, pick_value(),
                                   IDX_W'($urandom_range(0, 63))));
        repeat ($urandom_range(1, 5))
            issue_request(make_req(CMD_REMOVE, pick_value(), pick_index()));
        while (tracker.fill < LIST_CAPACITY)
            issue_request(make_req(pick_insert(1'b0), pick_value(),
                                   IDX_W'($urandom_range(0, 63))));
        issue_request(make_req(CMD_READ, pick_value(), 6'd63));
        if ($urandom_range(0, 1) == 0)
            issue_request(make_req(CMD_CLEAR, pick_value(),
                                   IDX_W'($urandom_range(0, 63))));
    endtask

    // Unstructured requests over all codes
    task automatic noise_episode();
        repeat ($urandom_range(10, 30))
            issue_request(make_req(CMD_W'($urandom_range(0, 7)), $urandom,
                                   IDX_W'($urandom_range(0, 63))));
    endtask

    initial
    begin
        int unsigned roll;
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        steady      = 1'b0;
        issued      = 0;
        cycle_count = 0;
        tracker     = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, spare codes, extremes, sort and range edges
        issue_request(make_req(CMD_READ, 32'sh0, 6'd0));
        issue_request(make_req(CMD_REMOVE, 32'sh0, 6'd63));
        issue_request(make_req(CMD_CLEAR, 32'sh0, 6'd0));
        issue_request(make_req(CMD_SPARE_A, 32'sh7FFF_FFFF, 6'd63));
        issue_request(make_req(CMD_SPARE_B, 32'sh8000_0000, 6'd0));
        issue_request(make_req(CMD_APPEND, 32'sh7FFF_FFFF, 6'd0));
        issue_request(make_req(CMD_APPEND, 32'sh8000_0000, 6'd63));
        issue_request(make_req(CMD_INSERT_HEAD, -32'sh1, 6'd0));
        issue_request(make_req(CMD_INSERT_HEAD, 32'sh0, 6'd0));
        // list is unsorted here: the sorted insert must reorder all of it
        issue_request(make_req(CMD_INSERT_SORTED, 32'sh5, 6'd0));
        issue_request(make_req(CMD_READ, 32'sh0, 6'd0));
        issue_request(make_req(CMD_READ, 32'sh0, 6'd4));
        issue_request(make_req(CMD_READ, 32'sh0, 6'd5));
        issue_request(make_req(CMD_INSERT_SORTED, 32'sh3, 6'd0));
        issue_request(make_req(CMD_INSERT_SORTED, 32'sh8000_0000, 6'd0));
        issue_request(make_req(CMD_REMOVE, 32'sh0, 6'd0));
        issue_request(make_req(CMD_REMOVE, 32'sh0, 6'd5));
        issue_request(make_req(CMD_REMOVE, 32'sh0, 6'd2));
        issue_request(make_req(CMD_READ, 32'sh0, 6'd63));
        issue_request(make_req(CMD_REMOVE, 32'sh0, 6'd4));
        issue_request(make_req(CMD_READ, 32'sh0, 6'd3));
        issue_request(make_req(CMD_CLEAR, 32'sh0, 6'd0));
        issue_request(make_req(CMD_READ, 32'sh0, 6'd0));
        issue_request(make_req(CMD_INSERT_SORTED, 32'sh0, 6'd0));
        issue_request(make_req(CMD_INSERT_HEAD, 32'sh7FFF_FFFF, 6'd0));

        // Random: episodes with their own idle profile, one fill up front
        base_count = issued;
        steady     = ($urandom_range(0, 3) == 0);
        fill_episode();
        while (issued - base_count < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            roll   = $urandom_range(0, 99);
            if (roll <= 5)
                fill_episode();
            else if (roll <= 17)
                noise_episode();
            else
                grow_episode();
        end
        start <= 1'b0;

        // Drain, then watch for stray results
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.expected_results.size() != 0)
            tracker.report($sformatf("%0d results never arrived",
                                     tracker.expected_results.size()));

        $display("ran %0d requests, %0d results compared, %0d sorted inserts",
                 tracker.accepted, tracker.checked, tracker.sorted_inserts);
        $display("list full on %0d results, %0d inserts refused, %0d index misses",
                 tracker.full_results, tracker.refused, tracker.out_of_range);
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: bounded_array_list_engine_unit.f
rtl/bale_pkg.sv
rtl/bale_ram.sv
rtl/bounded_array_list_engine_unit.sv
rtl/bale_checker.sv
dv/testbench.sv
